// ----- sv/cgcmr_pkg.sv -----
package cgcmr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FACTOR = 8'd1;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd29491;
    localparam logic [SAMPLE_W-1:0] FACTOR_RESET = 16'd9830;

    // Front sequencer states.
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_READ = 2'd1;
    localparam logic [1:0] F_SUMS = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    // Back sequencer states.
    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_ISSUE = 3'd1;
    localparam logic [2:0] B_WAIT = 3'd2;
    localparam logic [2:0] B_DEC = 3'd3;
    localparam logic [2:0] B_OUT = 3'd4;

    // Steps of the correlation test, one multiplication each.
    localparam logic [3:0] ST_N_SXY = 4'd0;
    localparam logic [3:0] ST_SX_SY = 4'd1;
    localparam logic [3:0] ST_N_SXX = 4'd2;
    localparam logic [3:0] ST_SX_SX = 4'd3;
    localparam logic [3:0] ST_N_SYY = 4'd4;
    localparam logic [3:0] ST_SY_SY = 4'd5;
    localparam logic [3:0] ST_C_C = 4'd6;
    localparam logic [3:0] ST_T_T = 4'd7;
    localparam logic [3:0] ST_TT_VX = 4'd8;
    localparam logic [3:0] ST_TTV_VY = 4'd9;

endpackage

// ----- sv/correlation_gated_common_mode_reducer.sv -----
// Correlation-gated common-mode reducer for a stereo sample stream.
// Input words arrive on the s_axis channel, one channel pair per word, and
// results leave on m_axis, one result word per input word, in order.
// Registers are written on the cfg channel (index 0: threshold, 1: factor),
// which is always ready; write only while no word is in flight.
// The front stage takes a word, updates the history memory and the running
// sums, and hands the sums to a two-entry queue.
// The back stage runs the exact correlation test on one shift-and-add
// multiplier, one bit per cycle: up to ten products a word, fewer when a
// channel is flat, and none while the window fills.
// The slower of the two stages sets the sustained rate; the front runs ahead
// while the back works.
// A stalled m_axis receiver holds the result in the output register; the
// back stage finishes the next word, then waits, and the queue fills
// before s_axis_tready drops.
// Reset empties the window and the queue and restores both registers;
// the history memory is not cleared, since entries are used only after
// they are written.
module correlation_gated_common_mode_reducer import cgcmr_pkg::*; #(
    parameter int WINDOW = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,   // first_sample, second_sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [31:0]            m_axis_tdata,   // first_result, second_result
    output logic [1:0]             m_axis_tuser,   // window_full, reduction_applied
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [15:0]            i_cfg_data
);

    localparam int LW = $clog2(WINDOW + 1);
    localparam int QW = 33 + 2 * (16 + LW) + 3 * (32 + LW);

    logic [15:0]   r_thr;
    logic [15:0]   r_rf;
    logic          w_qvalid_in;
    logic          w_qready_in;
    logic [QW-1:0] w_qdata_in;
    logic          w_qvalid_out;
    logic          w_qready_out;
    logic [QW-1:0] w_qdata_out;
    logic [15:0]   w_r1;
    logic [15:0]   w_r2;
    logic          w_full;
    logic          w_app;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESHOLD_RESET;
            r_rf  <= FACTOR_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_THRESHOLD) begin
                r_thr <= i_cfg_data;
            end else if (i_cfg_index == REG_FACTOR) begin
                r_rf <= i_cfg_data;
            end
        end
    end

    cgcmr_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_x      (signed'(s_axis_tdata[15:0])),
        .i_y      (signed'(s_axis_tdata[31:16])),
        .o_qvalid (w_qvalid_in),
        .i_qready (w_qready_in),
        .o_qdata  (w_qdata_in)
    );

    cgcmr_fifo #(
        .DATA_W (QW)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wvalid (w_qvalid_in),
        .o_wready (w_qready_in),
        .i_wdata  (w_qdata_in),
        .o_rvalid (w_qvalid_out),
        .i_rready (w_qready_out),
        .o_rdata  (w_qdata_out)
    );

    cgcmr_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (w_qvalid_out),
        .o_qready (w_qready_out),
        .i_qdata  (w_qdata_out),
        .i_thr    (r_thr),
        .i_rf     (r_rf),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_r1     (w_r1),
        .o_r2     (w_r2),
        .o_full   (w_full),
        .o_app    (w_app)
    );

    assign m_axis_tdata = {w_r2, w_r1};
    assign m_axis_tuser = {w_app, w_full};

endmodule

// ----- sv/cgcmr_fifo.sv -----
module cgcmr_fifo import cgcmr_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wvalid,
    output logic              o_wready,
    input  logic [DATA_W-1:0] i_wdata,
    output logic              o_rvalid,
    input  logic              i_rready,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2];
    logic [1:0]        r_cnt;
    logic              r_wr;
    logic              r_rd;
    logic              w_push;
    logic              w_pop;

    assign o_wready = (r_cnt != 2'd2);
    assign o_rvalid = (r_cnt != 2'd0);
    assign o_rdata  = r_mem[r_rd];
    assign w_push   = i_wvalid && o_wready;
    assign w_pop    = o_rvalid && i_rready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

// ----- sv/cgcmr_front.sv -----
module cgcmr_front import cgcmr_pkg::*; #(
    parameter int WINDOW = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [15:0]    i_x,
    input  logic signed [15:0]    i_y,
    output logic                  o_qvalid,
    input  logic                  i_qready,
    output logic [33+2*(16+$clog2(WINDOW+1))+3*(32+$clog2(WINDOW+1))-1:0] o_qdata
);

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int LW = $clog2(WINDOW + 1);
    localparam int SW = 16 + LW;
    localparam int PW = 32 + LW;

    logic [1:0]            r_fst;
    logic [2:0]            r_k;
    logic signed [15:0]    r_x;
    logic signed [15:0]    r_y;
    logic [31:0]           r_rd;
    logic [31:0]           r_hist [WINDOW];
    logic                  r_old;
    logic                  r_full;
    logic [AW-1:0]         r_wpos;
    logic [LW-1:0]         r_fill;
    logic signed [SW-1:0]  r_sx;
    logic signed [SW-1:0]  r_sy;
    logic signed [PW-1:0]  r_sxy;
    logic signed [PW-1:0]  r_sxx;
    logic signed [PW-1:0]  r_syy;

    logic signed [15:0]    w_ox;
    logic signed [15:0]    w_oy;
    logic signed [15:0]    w_ma;
    logic signed [15:0]    w_mb;
    logic signed [31:0]    w_prod;
    logic signed [PW-1:0]  w_pext;
    logic signed [SW-1:0]  w_oxe;
    logic signed [SW-1:0]  w_oye;

    assign o_ready  = (r_fst == F_IDLE);
    assign o_qvalid = (r_fst == F_PUSH);
    assign o_qdata  = {r_syy, r_sxx, r_sxy, r_sy, r_sx, r_full, r_y, r_x};

    assign w_ox = signed'(r_rd[15:0]);
    assign w_oy = signed'(r_rd[31:16]);

    always_comb begin
        case (r_k)
            3'd0: begin w_ma = w_ox; w_mb = w_oy; end
            3'd1: begin w_ma = w_ox; w_mb = w_ox; end
            3'd2: begin w_ma = w_oy; w_mb = w_oy; end
            3'd3: begin w_ma = r_x;  w_mb = r_y;  end
            3'd4: begin w_ma = r_x;  w_mb = r_x;  end
            default: begin w_ma = r_y; w_mb = r_y; end
        endcase
    end

    // The leaving pair only counts once the window has wrapped.
    assign w_prod = (r_k < 3'd3 && !r_old) ? 32'sd0 : w_ma * w_mb;
    assign w_pext = PW'(w_prod);
    assign w_oxe  = r_old ? SW'(w_ox) : '0;
    assign w_oye  = r_old ? SW'(w_oy) : '0;

    always_ff @(posedge i_clk) begin
        if (r_fst == F_READ) begin
            r_rd <= r_hist[r_wpos];
            r_hist[r_wpos] <= {r_y, r_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fst  <= F_IDLE;
            r_k    <= 3'd0;
            r_wpos <= '0;
            r_fill <= '0;
            r_old  <= 1'b0;
            r_full <= 1'b0;
            r_sx   <= '0;
            r_sy   <= '0;
            r_sxy  <= '0;
            r_sxx  <= '0;
            r_syy  <= '0;
        end else begin
            case (r_fst)
                F_IDLE: begin
                    if (i_valid) begin
                        r_x   <= i_x;
                        r_y   <= i_y;
                        r_fst <= F_READ;
                    end
                end
                F_READ: begin
                    r_old <= (r_fill == LW'(WINDOW));
                    if (r_fill == LW'(WINDOW)) begin
                        r_full <= 1'b1;
                    end else begin
                        r_fill <= r_fill + 1'b1;
                        r_full <= (r_fill + 1'b1 == LW'(WINDOW));
                    end
                    r_k   <= 3'd0;
                    r_fst <= F_SUMS;
                end
                F_SUMS: begin
                    case (r_k)
                        3'd0: begin
                            r_sxy <= r_sxy - w_pext;
                            r_sx  <= r_sx + SW'(r_x) - w_oxe;
                            r_sy  <= r_sy + SW'(r_y) - w_oye;
                        end
                        3'd1: r_sxx <= r_sxx - w_pext;
                        3'd2: r_syy <= r_syy - w_pext;
                        3'd3: r_sxy <= r_sxy + w_pext;
                        3'd4: r_sxx <= r_sxx + w_pext;
                        default: r_syy <= r_syy + w_pext;
                    endcase
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd5) begin
                        r_fst <= F_PUSH;
                    end
                end
                default: begin
                    if (i_qready) begin
                        r_wpos <= (r_wpos == AW'(WINDOW - 1)) ? '0 : r_wpos + 1'b1;
                        r_fst  <= F_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ----- sv/cgcmr_mul.sv -----
module cgcmr_mul import cgcmr_pkg::*; #(
    parameter int A_W = 32,
    parameter int B_W = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output logic           o_done,
    output logic [A_W-1:0] o_p
);

    logic [A_W-1:0] r_a;
    logic [B_W-1:0] r_b;
    logic [A_W-1:0] r_acc;
    logic           r_run;

    // Shift-and-add, one multiplier bit a cycle; stops when no bits remain.
    assign o_done = r_run && (r_b == '0);
    assign o_p    = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
        end else if (o_done) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_run && r_b != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

endmodule

// ----- sv/cgcmr_back.sv -----
module cgcmr_back import cgcmr_pkg::*; #(
    parameter int WINDOW = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_qvalid,
    output logic               o_qready,
    input  logic [33+2*(16+$clog2(WINDOW+1))+3*(32+$clog2(WINDOW+1))-1:0] i_qdata,
    input  logic [15:0]        i_thr,
    input  logic [15:0]        i_rf,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [15:0]        o_r1,
    output logic [15:0]        o_r2,
    output logic               o_full,
    output logic               o_app
);

    localparam int LW  = $clog2(WINDOW + 1);
    localparam int SW  = 16 + LW;
    localparam int PW  = 32 + LW;
    localparam int CW  = 32 + 2 * LW;
    localparam int CMW = CW - 1;
    localparam int RW  = 2 * CMW + 31;

    logic [2:0]            r_bst;
    logic [3:0]            r_step;
    logic signed [15:0]    r_x;
    logic signed [15:0]    r_y;
    logic                  r_full;
    logic signed [SW-1:0]  r_sx;
    logic signed [SW-1:0]  r_sy;
    logic signed [PW-1:0]  r_sxy;
    logic signed [PW-1:0]  r_sxx;
    logic signed [PW-1:0]  r_syy;
    logic signed [CW-1:0]  r_c;
    logic signed [CW-1:0]  r_vx;
    logic signed [CW-1:0]  r_vy;
    logic [RW-1:0]         r_l;
    logic [RW-1:0]         r_tmp;
    logic                  r_app;
    logic [15:0]           r_res1;
    logic [15:0]           r_res2;
    logic                  r_ov;
    logic [15:0]           r_o1;
    logic [15:0]           r_o2;
    logic                  r_ofull;
    logic                  r_oapp;

    logic [SW-1:0]         w_sx_mag;
    logic [SW-1:0]         w_sy_mag;
    logic [PW-1:0]         w_sxy_mag;
    logic [CW-1:0]         w_c_mag;
    logic signed [16:0]    w_t_ext;
    logic [16:0]           w_t_mag;
    logic [RW-1:0]         w_ma;
    logic [CMW-1:0]        w_mb;
    logic                  w_start;
    logic                  w_done;
    logic [RW-1:0]         w_p;
    logic signed [CW-1:0]  w_pc;
    logic signed [CW-1:0]  w_vy_next;
    logic                  w_flat;
    logic signed [16:0]    w_sum;
    logic signed [16:0]    w_fac;
    logic signed [33:0]    w_prod;
    logic signed [18:0]    w_d1;
    logic signed [18:0]    w_d2;
    logic [15:0]           w_s1;
    logic [15:0]           w_s2;
    logic                  w_out_free;

    assign o_qready = (r_bst == B_IDLE);
    assign o_tvalid = r_ov;
    assign o_r1     = r_o1;
    assign o_r2     = r_o2;
    assign o_full   = r_ofull;
    assign o_app    = r_oapp;

    assign w_sx_mag  = r_sx[SW-1] ? SW'(-r_sx) : SW'(r_sx);
    assign w_sy_mag  = r_sy[SW-1] ? SW'(-r_sy) : SW'(r_sy);
    assign w_sxy_mag = r_sxy[PW-1] ? PW'(-r_sxy) : PW'(r_sxy);
    assign w_c_mag   = r_c[CW-1] ? CW'(-r_c) : CW'(r_c);
    assign w_t_ext   = {i_thr[15], i_thr};
    assign w_t_mag   = w_t_ext[16] ? 17'(-w_t_ext) : 17'(w_t_ext);

    always_comb begin
        case (r_step)
            ST_N_SXY: begin w_ma = RW'(w_sxy_mag); w_mb = CMW'(WINDOW); end
            ST_SX_SY: begin w_ma = RW'(w_sx_mag);  w_mb = CMW'(w_sy_mag); end
            ST_N_SXX: begin w_ma = RW'($unsigned(r_sxx)); w_mb = CMW'(WINDOW); end
            ST_SX_SX: begin w_ma = RW'(w_sx_mag);  w_mb = CMW'(w_sx_mag); end
            ST_N_SYY: begin w_ma = RW'($unsigned(r_syy)); w_mb = CMW'(WINDOW); end
            ST_SY_SY: begin w_ma = RW'(w_sy_mag);  w_mb = CMW'(w_sy_mag); end
            ST_C_C:   begin w_ma = RW'(w_c_mag);   w_mb = w_c_mag[CMW-1:0]; end
            ST_T_T:   begin w_ma = RW'(w_t_mag);   w_mb = CMW'(w_t_mag); end
            ST_TT_VX: begin w_ma = r_tmp;          w_mb = r_vx[CMW-1:0]; end
            default:  begin w_ma = r_tmp;          w_mb = r_vy[CMW-1:0]; end
        endcase
    end

    assign w_start = (r_bst == B_ISSUE);

    cgcmr_mul #(
        .A_W (RW),
        .B_W (CMW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_done),
        .o_p     (w_p)
    );

    assign w_pc      = signed'(w_p[CW-1:0]);
    assign w_vy_next = r_vy - w_pc;

    // A flat channel counts as zero correlation.
    assign w_flat = (r_step == ST_SY_SY) &&
                    (r_vx[CW-1] || r_vx == '0 || w_vy_next[CW-1] || w_vy_next == '0);

    // Common part: floor((x + y) * factor / 65536), then saturate each channel.
    assign w_sum  = 17'(r_x) + 17'(r_y);
    assign w_fac  = signed'({1'b0, i_rf});
    assign w_prod = w_sum * w_fac;
    assign w_d1   = 19'(r_x) - 19'(signed'(w_prod[33:16]));
    assign w_d2   = 19'(r_y) - 19'(signed'(w_prod[33:16]));
    assign w_s1   = (w_d1 > 19'sd32767) ? 16'h7fff :
                    (w_d1 < -19'sd32768) ? 16'h8000 : w_d1[15:0];
    assign w_s2   = (w_d2 > 19'sd32767) ? 16'h7fff :
                    (w_d2 < -19'sd32768) ? 16'h8000 : w_d2[15:0];

    assign w_out_free = !r_ov || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bst  <= B_IDLE;
            r_step <= ST_N_SXY;
            r_ov   <= 1'b0;
            r_app  <= 1'b0;
        end else begin
            if (r_bst == B_OUT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (i_tready) begin
                r_ov <= 1'b0;
            end
            case (r_bst)
                B_IDLE: begin
                    if (i_qvalid) begin
                        r_app  <= 1'b0;
                        r_step <= ST_N_SXY;
                        r_bst  <= i_qdata[32] ? B_ISSUE : B_DEC;
                    end
                end
                B_ISSUE: begin
                    r_bst <= B_WAIT;
                end
                B_WAIT: begin
                    if (w_done) begin
                        r_step <= r_step + 4'd1;
                        r_bst  <= (w_flat || r_step == ST_TTV_VY) ? B_DEC : B_ISSUE;
                        case (r_step)
                            ST_N_SXY: r_c <= r_sxy[PW-1] ? -w_pc : w_pc;
                            ST_SX_SY: r_c <= (r_sx[SW-1] ^ r_sy[SW-1]) ? r_c + w_pc
                                                                       : r_c - w_pc;
                            ST_N_SXX: r_vx <= w_pc;
                            ST_SX_SX: r_vx <= r_vx - w_pc;
                            ST_N_SYY: r_vy <= w_pc;
                            ST_SY_SY: begin
                                r_vy <= w_vy_next;
                                if (w_flat) begin
                                    r_app <= i_thr[15];
                                end
                            end
                            ST_C_C:   r_l <= w_p << 30;
                            ST_T_T:   r_tmp <= w_p;
                            ST_TT_VX: r_tmp <= w_p;
                            default: begin
                                if (!i_thr[15]) begin
                                    r_app <= !r_c[CW-1] && (r_c != '0) && (r_l > w_p);
                                end else begin
                                    r_app <= !r_c[CW-1] || (r_l < w_p);
                                end
                            end
                        endcase
                    end
                end
                B_DEC: begin
                    r_bst <= B_OUT;
                end
                default: begin
                    if (w_out_free) begin
                        r_bst <= B_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_bst == B_IDLE && i_qvalid) begin
            r_x    <= signed'(i_qdata[15:0]);
            r_y    <= signed'(i_qdata[31:16]);
            r_full <= i_qdata[32];
            r_sx   <= signed'(i_qdata[33 +: SW]);
            r_sy   <= signed'(i_qdata[33+SW +: SW]);
            r_sxy  <= signed'(i_qdata[33+2*SW +: PW]);
            r_sxx  <= signed'(i_qdata[33+2*SW+PW +: PW]);
            r_syy  <= signed'(i_qdata[33+2*SW+2*PW +: PW]);
        end
        if (r_bst == B_DEC) begin
            r_res1 <= r_app ? w_s1 : r_x;
            r_res2 <= r_app ? w_s2 : r_y;
        end
        if (r_bst == B_OUT && w_out_free) begin
            r_o1    <= r_res1;
            r_o2    <= r_res2;
            r_ofull <= r_full;
            r_oapp  <= r_app;
        end
    end

`ifndef NO_ASSERTIONS
    a_app_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bst == B_OUT && r_app) |-> r_full)
        else $error("reduction flagged on a word whose window was not full");
    a_variance_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bst == B_ISSUE && (r_step == ST_TT_VX || r_step == ST_TTV_VY))
        |-> (!r_vx[CW-1] && r_vx != '0 && !r_vy[CW-1] && r_vy != '0))
        else $error("variance product started with a non-positive variance");
    a_wait_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bst == B_ISSUE) |=> (r_bst == B_WAIT && $stable(r_step)))
        else $error("multiplier step lost after issue");
`endif

endmodule
